/* rtl/mzbpt_pkg.sv */
// shared widths, codes and table entry type of the binned peak table
`timescale 1ns / 1ps
`default_nettype none

package mzbpt_pkg;

  // field widths
  localparam int MZ_W   = 22;
  localparam int INT_W  = 32;
  localparam int TOL_W  = 16;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 48;
  localparam int OPND_W = MZ_W + 1;  // mz + tol needs one more bit

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // request opcodes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // one bin of the table
  typedef struct packed {
    logic             valid;
    logic [MZ_W-1:0]  mz;
    logic [INT_W-1:0] inten;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/mzbpt_ram.sv */
// generic single write, single read port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mzbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/mzbpt_binidx.sv */
// shared bin index unit: scale m/z to a bin, optional round half up, clamp to the table
`timescale 1ns / 1ps
`default_nettype none

module mzbpt_binidx #(
  parameter int BINS_PER_MZ = 4,
  parameter int FRAC_BITS   = 10,
  parameter int DEPTH       = 16384
) (
  input  wire logic                                      clk_i,
  input  wire logic [mzbpt_pkg::OPND_W-1:0]              operand_i,
  input  wire logic                                      round_i,
  output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] bin_o,
  output logic                                           over_o
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BPM_W = $clog2(BINS_PER_MZ + 1);
  localparam int PRD_W = mzbpt_pkg::OPND_W + BPM_W + 1;
  localparam int CMP_W = (PRD_W > AW + 1) ? PRD_W : AW + 1;

  localparam logic [PRD_W-1:0] HALF_C  = PRD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PRD_W-1:0] BPM_C   = PRD_W'(BINS_PER_MZ);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [AW-1:0]    LAST_C  = AW'(DEPTH - 1);

  logic [PRD_W-1:0] prod;
  logic [PRD_W-1:0] rounded;
  logic [CMP_W-1:0] bin_wide;
  logic             over;
  logic [AW-1:0]    bin_q;
  logic             over_q;

  always_comb begin
    prod     = PRD_W'(operand_i) * BPM_C;
    rounded  = prod + (round_i ? HALF_C : '0);
    bin_wide = CMP_W'(rounded >> FRAC_BITS);
    over     = (bin_wide >= DEPTH_C);
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= over ? LAST_C : bin_wide[AW-1:0];
    over_q <= over;
  end

  assign bin_o  = bin_q;
  assign over_o = over_q;

endmodule

`default_nettype wire

/* rtl/mz_binned_peak_table_nearest_core.sv */
// top level of the binned peak table with nearest peak lookup
`timescale 1ns / 1ps
`default_nettype none

// Binned peak table for one mass spectrum, m/z in 1/2^FRAC_BITS Th.
// A request is taken on start while busy is low; op selects insert, nearest
// peak query or clear. Every request gives exactly one result, shown for one
// cycle with done_o high; the receiver cannot hold it off. The statistics
// ports show the state after the request that caused the result.
// Steps from accept to done_o:
//   insert, nonzero intensity : bin index and table read, then write back
//   insert with zero, op 3    : result straight from idle
//   query                     : low and high window edge, one table read per bin,
//                               then a drain step
//   query with empty window   : low and high window edge only
//   clear                     : all table rows, one table row per cycle
//                               through the write port
// busy is low in the done_o cycle, so the next request may be taken there.
// After reset the table is swept once, one row a cycle, with busy high
// and no result; statistics are zero at once.
// One shared bin index unit (constant multiply, round, clamp) serves the
// insert bin and both query window edges.

module mz_binned_peak_table_nearest_core #(
  parameter int BINS_PER_MZ = 4,
  parameter int MAX_MZ      = 4096,
  parameter int FRAC_BITS   = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   op_i,
  input  wire logic [mzbpt_pkg::MZ_W-1:0]   mz_value_i,
  input  wire logic [mzbpt_pkg::INT_W-1:0]  intensity_i,
  input  wire logic [mzbpt_pkg::TOL_W-1:0]  tolerance_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic      [mzbpt_pkg::MZ_W-1:0]   peak_mz_o,
  output logic      [mzbpt_pkg::INT_W-1:0]  peak_intensity_o,
  output logic      [mzbpt_pkg::CNT_W-1:0]  peak_count_o,
  output logic      [mzbpt_pkg::MZ_W-1:0]   lowest_mz_o,
  output logic      [mzbpt_pkg::MZ_W-1:0]   highest_mz_o,
  output logic      [mzbpt_pkg::SUM_W-1:0]  intensity_sum_o
);

  localparam int DEPTH  = MAX_MZ * BINS_PER_MZ;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MZ_W   = mzbpt_pkg::MZ_W;
  localparam int INT_W  = mzbpt_pkg::INT_W;
  localparam int TOL_W  = mzbpt_pkg::TOL_W;
  localparam int CNT_W  = mzbpt_pkg::CNT_W;
  localparam int SUM_W  = mzbpt_pkg::SUM_W;
  localparam int OPND_W = mzbpt_pkg::OPND_W;
  localparam logic [AW-1:0] LAST_C = AW'(DEPTH - 1);

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_INS_RD = 8'b0000_0100,
    S_INS_WR = 8'b0000_1000,
    S_Q_LO   = 8'b0001_0000,
    S_Q_HI   = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_DRAIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // control
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_report_q, clr_report_d;
  logic             rd_pend_q, rd_pend_d;
  logic             hit_q, hit_d;
  logic             ins_over_q, ins_over_d;
  logic             lo_over_q, lo_over_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MZ_W-1:0]  min_q, min_d;
  logic [MZ_W-1:0]  max_q, max_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             done_q, done_d;
  logic             found_q, found_d;

  // payload
  logic [MZ_W-1:0]  mz_q;
  logic [INT_W-1:0] int_q;
  logic [TOL_W-1:0] tol_q;
  logic             neg_q;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AW-1:0]    lo_q, lo_d;
  logic [AW-1:0]    hi_q, hi_d;
  logic [MZ_W-1:0]  best_q, best_d;
  logic [MZ_W-1:0]  bmz_q, bmz_d;
  logic [INT_W-1:0] bint_q, bint_d;
  logic [MZ_W-1:0]  pmz_q, pmz_d;
  logic [INT_W-1:0] pint_q, pint_d;

  // shared bin index unit
  logic [OPND_W-1:0] operand;
  logic              round_en;
  logic [AW-1:0]     bin;
  logic              over;

  // table port
  logic                            we;
  logic [AW-1:0]                   waddr;
  mzbpt_pkg::entry_t               wdata;
  logic [AW-1:0]                   raddr;
  logic [mzbpt_pkg::ENTRY_W-1:0]   rdata;
  mzbpt_pkg::entry_t               ent;

  logic [OPND_W:0]   qdiff;
  logic [OPND_W-1:0] qsum;
  logic [MZ_W-1:0]   delta;
  logic              take;
  logic [SUM_W:0]    sum_ext;
  mzbpt_pkg::op_e    op;

  assign op    = mzbpt_pkg::op_e'(op_i);
  assign busy  = (state_q != S_IDLE);

  // low edge of the window, borrow marks mz below tol
  assign qdiff = {2'b00, mz_value_i} - (OPND_W + 1)'(tolerance_i);
  assign qsum  = OPND_W'(mz_q) + OPND_W'(tol_q);

  // operand select for the shared unit
  always_comb begin
    if (state_q == S_Q_LO) begin
      operand  = qsum;
      round_en = 1'b1;
    end else if (op == mzbpt_pkg::OP_QUERY) begin
      operand  = qdiff[OPND_W-1:0];
      round_en = 1'b1;
    end else begin
      operand  = OPND_W'(mz_value_i);
      round_en = 1'b0;
    end
  end

  mzbpt_binidx #(
    .BINS_PER_MZ (BINS_PER_MZ),
    .FRAC_BITS   (FRAC_BITS),
    .DEPTH       (DEPTH)
  ) u_binidx (
    .clk_i     (clk_i),
    .operand_i (operand),
    .round_i   (round_en),
    .bin_o     (bin),
    .over_o    (over)
  );

  mzbpt_ram #(
    .WIDTH (mzbpt_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // candidate check on the entry read in the previous cycle
  always_comb begin
    ent   = mzbpt_pkg::entry_t'(rdata);
    delta = (ent.mz > mz_q) ? (ent.mz - mz_q) : (mz_q - ent.mz);
    take  = rd_pend_q && ent.valid && (delta <= MZ_W'(tol_q)) &&
            (!hit_q || (delta < best_q));
  end

  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(int_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    clr_report_d = clr_report_q;
    rd_pend_d    = 1'b0;
    hit_d        = hit_q;
    ins_over_d   = ins_over_q;
    lo_over_d    = lo_over_q;
    cnt_d        = cnt_q;
    min_d        = min_q;
    max_d        = max_q;
    sum_d        = sum_q;
    done_d       = 1'b0;
    found_d      = 1'b0;
    addr_d       = addr_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    best_d       = best_q;
    bmz_d        = bmz_q;
    bint_d       = bint_q;
    pmz_d        = '0;
    pint_d       = '0;
    we           = 1'b0;
    waddr        = addr_q;
    wdata        = '0;
    raddr        = addr_q;

    // nearest so far; strictly closer only, so the lower bin wins a tie
    if (take) begin
      hit_d  = 1'b1;
      best_d = delta;
      bmz_d  = ent.mz;
      bint_d = ent.inten;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op)
            mzbpt_pkg::OP_INSERT: begin
              if (intensity_i != '0) begin
                state_d = S_INS_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            mzbpt_pkg::OP_QUERY: begin
              state_d = S_Q_LO;
            end
            mzbpt_pkg::OP_CLEAR: begin
              cnt_d        = '0;
              min_d        = '0;
              max_d        = '0;
              sum_d        = '0;
              clr_addr_d   = '0;
              clr_report_d = 1'b1;
              state_d      = S_CLEAR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_q;
        if (clr_addr_q == LAST_C) begin
          done_d       = clr_report_q;
          clr_report_d = 1'b0;
          state_d      = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end

      S_INS_RD: begin
        raddr      = bin;
        addr_d     = bin;
        ins_over_d = over;
        if (cnt_q == '0) begin
          min_d = mz_q;
          max_d = mz_q;
        end else begin
          if (mz_q < min_q) begin
            min_d = mz_q;
          end
          if (mz_q > max_q) begin
            max_d = mz_q;
          end
        end
        if (cnt_q != mzbpt_pkg::CNT_MAX) begin
          cnt_d = cnt_q + 1'b1;
        end
        sum_d   = sum_ext[SUM_W] ? mzbpt_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
        state_d = S_INS_WR;
      end

      S_INS_WR: begin
        // keep the stronger peak of the bin
        if (!ins_over_q && (!ent.valid || (ent.inten < int_q))) begin
          we          = 1'b1;
          waddr       = addr_q;
          wdata.valid = 1'b1;
          wdata.mz    = mz_q;
          wdata.inten = int_q;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_Q_LO: begin
        lo_d      = neg_q ? '0 : bin;
        lo_over_d = !neg_q && over;
        state_d   = S_Q_HI;
      end

      S_Q_HI: begin
        // bin holds the clamped high edge here
        if (lo_over_q || (lo_q > bin)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          addr_d  = lo_q;
          hi_d    = bin;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        raddr     = addr_q;
        rd_pend_d = 1'b1;
        if (addr_q == hi_q) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      S_DRAIN: begin
        done_d  = 1'b1;
        found_d = hit_d;
        pmz_d   = hit_d ? bmz_d : '0;
        pint_d  = hit_d ? bint_d : '0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers; reset starts the table sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      clr_report_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      ins_over_q   <= 1'b0;
      lo_over_q    <= 1'b0;
      cnt_q        <= '0;
      min_q        <= '0;
      max_q        <= '0;
      sum_q        <= '0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_report_q <= clr_report_d;
      rd_pend_q    <= rd_pend_d;
      hit_q        <= hit_d;
      ins_over_q   <= ins_over_d;
      lo_over_q    <= lo_over_d;
      cnt_q        <= cnt_d;
      min_q        <= min_d;
      max_q        <= max_d;
      sum_q        <= sum_d;
      done_q       <= done_d;
      found_q      <= found_d;
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      mz_q  <= mz_value_i;
      int_q <= intensity_i;
      tol_q <= tolerance_i;
      neg_q <= qdiff[OPND_W];
    end
    addr_q <= addr_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    best_q <= best_d;
    bmz_q  <= bmz_d;
    bint_q <= bint_d;
    pmz_q  <= pmz_d;
    pint_q <= pint_d;
  end

  assign done_o           = done_q;
  assign found_o          = found_q;
  assign peak_mz_o        = pmz_q;
  assign peak_intensity_o = pint_q;
  assign peak_count_o     = cnt_q;
  assign lowest_mz_o      = min_q;
  assign highest_mz_o     = max_q;
  assign intensity_sum_o  = sum_q;

endmodule

`default_nettype wire

/* rtl/mzbpt_checker.sv */
// port level checks of the binned peak table and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module mzbpt_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done_o,
  input wire logic                         found_o,
  input wire logic [mzbpt_pkg::MZ_W-1:0]   peak_mz_o,
  input wire logic [mzbpt_pkg::INT_W-1:0]  peak_intensity_o
);

  // a result only comes once the block is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // an accepted request either keeps the block busy or finishes at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither busy nor done");

  // a hit is only reported with a result
  a_found_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> done_o)
    else $error("found without result strobe");

  // a miss carries no peak
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> ((peak_mz_o == '0) && (peak_intensity_o == '0)))
    else $error("peak fields nonzero on a miss");

  // no result without a request taken earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !done_o && !start) |=> !done_o)
    else $error("result without a request");

endmodule

bind mz_binned_peak_table_nearest_core mzbpt_checker u_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for the binned peak table with nearest peak lookup
`timescale 1ns / 1ps

module tb;

  localparam int MZ_W  = mzbpt_pkg::MZ_W;
  localparam int INT_W = mzbpt_pkg::INT_W;
  localparam int TOL_W = mzbpt_pkg::TOL_W;
  localparam int CNT_W = mzbpt_pkg::CNT_W;
  localparam int SUM_W = mzbpt_pkg::SUM_W;

  localparam int BINS_PER_MZ = 4;
  localparam int MAX_MZ      = 4096;
  localparam int FRAC_BITS   = 10;
  localparam int TABLE_BINS  = MAX_MZ * BINS_PER_MZ;
  localparam longint unsigned HALF_BIN = 64'd1 << (FRAC_BITS - 1);

  localparam logic [1:0]       OP_UNUSED = 2'd3;
  localparam logic [MZ_W-1:0]  MZ_TOP    = '1;
  localparam logic [INT_W-1:0] INT_TOP   = '1;
  localparam logic [TOL_W-1:0] TOL_TOP   = '1;

  localparam int     CLK_HALF         = 6;
  localparam int     RESET_CYCLES     = 6;
  localparam longint CYCLE_LIMIT      = 3_000_000;
  localparam int     DRAIN_CYCLES     = 600;    // beyond the widest query scan
  localparam int     REPORT_MAX       = 10;

  typedef struct packed {
    logic             found;
    logic [MZ_W-1:0]  peak_mz;
    logic [INT_W-1:0] peak_intensity;
    logic [CNT_W-1:0] peak_count;
    logic [MZ_W-1:0]  lowest_mz;
    logic [MZ_W-1:0]  highest_mz;
    logic [SUM_W-1:0] intensity_sum;
  } peak_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [1:0]       op_i        = '0;
  logic [MZ_W-1:0]  mz_value_i  = '0;
  logic [INT_W-1:0] intensity_i = '0;
  logic [TOL_W-1:0] tolerance_i = '0;
  logic             busy;
  logic             done_o;
  logic             found_o;
  logic [MZ_W-1:0]  peak_mz_o;
  logic [INT_W-1:0] peak_intensity_o;
  logic [CNT_W-1:0] peak_count_o;
  logic [MZ_W-1:0]  lowest_mz_o;
  logic [MZ_W-1:0]  highest_mz_o;
  logic [SUM_W-1:0] intensity_sum_o;

  // predicted copy of the peak store and its statistics
  logic             store_valid [TABLE_BINS];
  logic [MZ_W-1:0]  store_mz    [TABLE_BINS];
  logic [INT_W-1:0] store_inten [TABLE_BINS];
  logic [CNT_W-1:0] stat_count;
  logic [MZ_W-1:0]  stat_lowest;
  logic [MZ_W-1:0]  stat_highest;
  logic [SUM_W-1:0] stat_sum;

  peak_result_t expected_peaks[$];
  int           mismatch_count = 0;
  int           result_count   = 0;
  longint       cycle_count    = 0;
  bit           no_idle        = 1'b0;

  mz_binned_peak_table_nearest_core #(
    .BINS_PER_MZ(BINS_PER_MZ),
    .MAX_MZ     (MAX_MZ),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .mz_value_i      (mz_value_i),
    .intensity_i     (intensity_i),
    .tolerance_i     (tolerance_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .peak_mz_o       (peak_mz_o),
    .peak_intensity_o(peak_intensity_o),
    .peak_count_o    (peak_count_o),
    .lowest_mz_o     (lowest_mz_o),
    .highest_mz_o    (highest_mz_o),
    .intensity_sum_o (intensity_sum_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  function automatic void clear_store();
    for (int b = 0; b < TABLE_BINS; b++) begin
      store_valid[b] = 1'b0;
      store_mz[b]    = '0;
      store_inten[b] = '0;
    end
    stat_count   = '0;
    stat_lowest  = '0;
    stat_highest = '0;
    stat_sum     = '0;
  endfunction

  // applies one request to the predicted store and returns the result it gives
  function automatic peak_result_t predict_peak_result(logic [1:0] op,
      logic [MZ_W-1:0] mz, logic [INT_W-1:0] inten, logic [TOL_W-1:0] tol);
    peak_result_t    res;
    longint unsigned bin;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned delta;
    longint unsigned best_dist;
    longint unsigned sum;
    res       = '0;
    best_dist = 0;
    case (op)
      mzbpt_pkg::OP_INSERT: begin
        if (inten != '0) begin
          bin = (64'(mz) * BINS_PER_MZ) >> FRAC_BITS;
          if (bin < TABLE_BINS) begin
            // a bin keeps the peak with strictly higher intensity
            if (!store_valid[int'(bin)] || store_inten[int'(bin)] < inten) begin
              store_valid[int'(bin)] = 1'b1;
              store_mz[int'(bin)]    = mz;
              store_inten[int'(bin)] = inten;
            end
          end
          if (stat_count == '0) begin
            stat_lowest  = mz;
            stat_highest = mz;
          end else begin
            if (mz < stat_lowest) stat_lowest = mz;
            if (mz > stat_highest) stat_highest = mz;
          end
          if (stat_count != mzbpt_pkg::CNT_MAX) stat_count = stat_count + 1'b1;
          sum      = 64'(stat_sum) + 64'(inten);
          stat_sum = (sum > 64'(mzbpt_pkg::SUM_MAX)) ? mzbpt_pkg::SUM_MAX
                                                      : sum[SUM_W-1:0];
        end
      end
      mzbpt_pkg::OP_QUERY: begin
        // window edges rounded half up, low edge floored at zero, high edge clamped
        if (mz < tol) lo = 0;
        else lo = ((64'(mz) - 64'(tol)) * BINS_PER_MZ + HALF_BIN) >> FRAC_BITS;
        hi = ((64'(mz) + 64'(tol)) * BINS_PER_MZ + HALF_BIN) >> FRAC_BITS;
        if (hi > TABLE_BINS - 1) hi = TABLE_BINS - 1;
        for (longint unsigned b = lo; b <= hi; b++) begin
          if (store_valid[int'(b)]) begin
            if (store_mz[int'(b)] > mz) delta = 64'(store_mz[int'(b)]) - 64'(mz);
            else delta = 64'(mz) - 64'(store_mz[int'(b)]);
            // strictly closer only, so the lower bin wins a tie
            if (delta <= tol && (!res.found || delta < best_dist)) begin
              res.found          = 1'b1;
              best_dist          = delta;
              res.peak_mz        = store_mz[int'(b)];
              res.peak_intensity = store_inten[int'(b)];
            end
          end
        end
      end
      mzbpt_pkg::OP_CLEAR: clear_store();
      default: ;
    endcase
    res.peak_count    = stat_count;
    res.lowest_mz     = stat_lowest;
    res.highest_mz    = stat_highest;
    res.intensity_sum = stat_sum;
    return res;
  endfunction

  task automatic idle_gap();
    int pick;
    int gap;
    pick = $urandom_range(99);
    if (no_idle || pick < 45) gap = 0;
    else if (pick < 88) gap = $urandom_range(3, 1);
    else if (pick < 97) gap = $urandom_range(12, 4);
    else gap = $urandom_range(60, 20);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // start stays high from one request to the next unless a gap lowers it
  task automatic send_request(logic [1:0] op, logic [MZ_W-1:0] mz,
      logic [INT_W-1:0] inten, logic [TOL_W-1:0] tol);
    peak_result_t predicted;
    start       <= 1'b1;
    op_i        <= op;
    mz_value_i  <= mz;
    intensity_i <= inten;
    tolerance_i <= tol;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    predicted      = predict_peak_result(op, mz, inten, tol);
    expected_peaks = {expected_peaks, predicted};
    idle_gap();
  endtask

  task automatic send_random_item(logic [MZ_W-1:0] centre, int spread);
    int               pick;
    longint           m;
    logic [1:0]       op;
    logic [MZ_W-1:0]  mz;
    logic [INT_W-1:0] inten;
    logic [TOL_W-1:0] tol;
    m = longint'(centre) + longint'($urandom_range(2 * spread)) - spread;
    if (m < 0) m = 0;
    if (m > longint'(MZ_TOP)) m = longint'(MZ_TOP);
    mz   = m[MZ_W-1:0];
    pick = $urandom_range(99);
    if (pick < 30) inten = $urandom_range(4, 1);  // small values give equal intensities
    else if (pick < 92) inten = $urandom();
    else inten = '0;
    pick = $urandom_range(99);
    if (pick < 60) tol = TOL_W'($urandom_range(600));
    else if (pick < 85) tol = TOL_W'($urandom_range(4095));
    else if (pick < 95) tol = TOL_W'($urandom_range(TOL_TOP));
    else tol = '0;
    pick = $urandom_range(99);
    if (pick < 50) op = mzbpt_pkg::OP_INSERT;
    else if (pick < 90) op = mzbpt_pkg::OP_QUERY;
    else if (pick < 94) op = OP_UNUSED;
    else begin
      // noise: anything over the whole field ranges
      op    = ($urandom_range(1) == 0) ? mzbpt_pkg::OP_INSERT : mzbpt_pkg::OP_QUERY;
      mz    = MZ_W'($urandom_range(MZ_TOP));
      inten = $urandom();
      tol   = TOL_W'($urandom_range(TOL_TOP));
    end
    send_request(op, mz, inten, tol);
  endtask

  task automatic test_directed();
    send_request(mzbpt_pkg::OP_QUERY, 22'd1000, '0, 16'd100);   // empty store
    send_request(OP_UNUSED, MZ_TOP, INT_TOP, TOL_TOP);
    send_request(mzbpt_pkg::OP_INSERT, 22'd5000, '0, '0);       // zero intensity ignored
    send_request(mzbpt_pkg::OP_INSERT, '0, 32'd1, '0);
    send_request(mzbpt_pkg::OP_INSERT, 22'd200, 32'd1, '0);     // same bin, equal: kept
    send_request(mzbpt_pkg::OP_INSERT, 22'd255, 32'd5, '0);     // same bin, higher: replaced
    send_request(mzbpt_pkg::OP_INSERT, MZ_TOP, INT_TOP, '0);    // last bin
    send_request(mzbpt_pkg::OP_QUERY, '0, '0, '0);
    send_request(mzbpt_pkg::OP_QUERY, 22'd255, '0, '0);
    send_request(mzbpt_pkg::OP_QUERY, '0, '0, TOL_TOP);         // window below zero
    send_request(mzbpt_pkg::OP_QUERY, MZ_TOP, '0, '0);          // empty window
    send_request(mzbpt_pkg::OP_QUERY, MZ_TOP, '0, TOL_TOP);     // high edge clamped
    send_request(mzbpt_pkg::OP_INSERT, 22'd10240, 32'd7, '0);
    send_request(mzbpt_pkg::OP_INSERT, 22'd10752, 32'd9, '0);
    send_request(mzbpt_pkg::OP_QUERY, 22'd10496, '0, 16'd256);  // tie, lower bin wins
    send_request(mzbpt_pkg::OP_QUERY, 22'd10240, '0, '0);       // exact hit
    send_request(mzbpt_pkg::OP_QUERY, 22'd10496, '0, 16'd255);  // just out of reach
    send_request(mzbpt_pkg::OP_CLEAR, '0, '0, '0);
    send_request(mzbpt_pkg::OP_QUERY, 22'd10240, '0, '0);       // gone after clear
    send_request(mzbpt_pkg::OP_INSERT, 22'd50000, 32'd3, '0);   // first peak sets both limits
    send_request(mzbpt_pkg::OP_INSERT, 22'd40000, INT_TOP, '0);
    send_request(mzbpt_pkg::OP_INSERT, 22'd60000, 32'd2, '0);
    send_request(mzbpt_pkg::OP_QUERY, 22'd50000, INT_TOP, TOL_TOP);
    send_request(OP_UNUSED, '0, '0, '0);
  endtask

  // well-populated neighbourhoods so that most queries have something to find
  task automatic test_random_clusters();
    int               spread;
    logic [MZ_W-1:0]  centre;
    for (int phase = 0; phase < 5; phase++) begin
      send_request(mzbpt_pkg::OP_CLEAR, '0, '0, '0);
      centre = MZ_W'($urandom_range(MZ_TOP));
      case ($urandom_range(2))
        0:       spread = 64;
        1:       spread = 1024;
        default: spread = 8192;
      endcase
      for (int n = 0; n < 150; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
        send_random_item(centre, spread);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_range();
    send_request(mzbpt_pkg::OP_CLEAR, '0, '0, '0);
    for (int n = 0; n < 120; n++) send_random_item(22'h200000, 22'h200000);
    for (int n = 0; n < 30; n++) send_random_item(MZ_TOP, 2048);
  endtask

  // zero insert and unused op on a loaded store, then a query after clear
  task automatic test_loaded_store();
    send_request(mzbpt_pkg::OP_INSERT, 22'd12345, '0, '0);
    send_request(OP_UNUSED, '0, '0, '0);
    for (int n = 0; n < 20; n++) send_random_item(22'h200000, 22'h200000);
    send_request(mzbpt_pkg::OP_CLEAR, '0, '0, '0);
    send_request(mzbpt_pkg::OP_QUERY, 22'h200000, '0, TOL_TOP);
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("result %0d: %s expected %0h actual %0h", result_count, field, want, got);
    end
  endtask

  // each strobed result against the oldest prediction
  always @(posedge clk_i) begin
    peak_result_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (expected_peaks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result %0d: no request outstanding, found %b peak_mz %0h",
                   result_count, found_o, peak_mz_o);
      end else begin
        want = expected_peaks.pop_front();
        check_field("found", want.found, found_o);
        check_field("peak_mz", want.peak_mz, peak_mz_o);
        check_field("peak_intensity", want.peak_intensity, peak_intensity_o);
        check_field("peak_count", want.peak_count, peak_count_o);
        check_field("lowest_mz", want.lowest_mz, lowest_mz_o);
        check_field("highest_mz", want.highest_mz, highest_mz_o);
        check_field("intensity_sum", want.intensity_sum, intensity_sum_o);
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL mz_binned_peak_table_nearest_core");
      $finish;
    end
  end

  initial begin
    clear_store();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_clusters();
    test_full_range();
    test_loaded_store();
    start <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS mz_binned_peak_table_nearest_core");
    end else begin
      $display("FAIL mz_binned_peak_table_nearest_core");
    end
    $finish;
  end

endmodule
